### design/tco_pkg.sv
// ----------------------------------------------------------------------------
// Triangle / circle overlap test package
// Types and constants shared by the overlap pipeline.
// ----------------------------------------------------------------------------
package tco_pkg;

   // Kind of hit reported with each result, in order of precedence.
   typedef enum logic [1:0] {
      HIT_NONE   = 2'd0,
      HIT_VERTEX = 2'd1,
      HIT_CENTER = 2'd2,
      HIT_EDGE   = 2'd3
   } hit_kind_type;

   // Early decisions carried down the pipeline until the edge tests finish.
   typedef struct packed {
      logic vertex;
      logic center;
   } tco_flags_type;

   // Stages from the input transfer to the registered edge decisions.
   localparam int PIPE_DEPTH = 7;

   // Result payload: overlap, hit_kind, then zero padding to one byte.
   localparam int RSP_BITS = 8;

endpackage

### design/tco_edge_unit.sv
// ----------------------------------------------------------------------------
// Edge distance unit
// Seven-stage pipeline that decides whether the circle centre projects onto
// the inside of edge S->T and lies within the radius of that edge.
// ----------------------------------------------------------------------------
module tco_edge_unit #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         advance,
   input  logic signed [COORD_BITS-1:0] s_x,
   input  logic signed [COORD_BITS-1:0] s_y,
   input  logic signed [COORD_BITS-1:0] t_x,
   input  logic signed [COORD_BITS-1:0] t_y,
   input  logic signed [COORD_BITS-1:0] p_x,
   input  logic signed [COORD_BITS-1:0] p_y,
   input  logic        [COORD_BITS-2:0] radius,
   output logic                         hit
);

   localparam int DW  = COORD_BITS + 1;
   localparam int PW  = 2 * DW;
   localparam int SW  = PW + 1;
   localparam int RBW = COORD_BITS - 1;
   localparam int RW  = 2 * RBW;
   localparam int HL  = (SW + 1) / 2;
   localparam int HH  = SW - HL;
   localparam int RL  = (RW + 1) / 2;
   localparam int RH  = RW - RL;
   localparam int QW  = 2 * SW;

   // Stage 1: edge and centre offset vectors.
   logic signed [DW-1:0] ex_ff, ey_ff, cx_ff, cy_ff;
   logic        [RBW-1:0] rad_ff;
   // Stage 2: products.
   logic signed [PW-1:0] kx_ff, ky_ff, lx_ff, ly_ff, xa_ff, xb_ff;
   logic        [RW-1:0] r2_2_ff;
   // Stage 3: dot product, squared length and cross product.
   logic signed [SW-1:0] k_ff, len_ff, cross_ff;
   logic        [RW-1:0] r2_3_ff;
   // Stage 4: projection range check and cross magnitude.
   logic                 rng_4_ff;
   logic        [SW-1:0] cr_ff, len_u_ff;
   logic        [RW-1:0] r2_4_ff;
   // Stage 5: partial products of both sides of the distance compare.
   logic                 rng_5_ff;
   logic [2*HH-1:0]      chh_ff;
   logic [HH+HL-1:0]     chl_ff;
   logic [2*HL-1:0]      cll_ff;
   logic [RL+HL-1:0]     rll_ff;
   logic [RL+HH-1:0]     rlh_ff;
   logic [RH+HL-1:0]     rhl_ff;
   logic [RH+HH-1:0]     rhh_ff;
   // Stage 6: assembled squared cross product and radius term.
   logic                 rng_6_ff;
   logic [QW-1:0]        lhs_ff, rhs_ff;
   // Stage 7: decision.
   logic                 hit_ff;

   logic signed [SW-1:0] k_in, len_in, cross_in;
   logic        [SW-1:0] cr_in;
   logic [HH-1:0]        cr_hi;
   logic [HL-1:0]        cr_lo;
   logic [HH-1:0]        len_hi;
   logic [HL-1:0]        len_lo;
   logic [RH-1:0]        r2_hi;
   logic [RL-1:0]        r2_lo;
   logic [QW-1:0]        lhs_in, rhs_in;

   always_comb begin
      k_in     = SW'(kx_ff) + SW'(ky_ff);
      len_in   = SW'(lx_ff) + SW'(ly_ff);
      cross_in = SW'(xa_ff) - SW'(xb_ff);
      cr_in    = cross_ff[SW-1] ? SW'(-cross_ff) : SW'(cross_ff);
      cr_hi    = cr_ff[SW-1:HL];
      cr_lo    = cr_ff[HL-1:0];
      len_hi   = len_u_ff[SW-1:HL];
      len_lo   = len_u_ff[HL-1:0];
      r2_hi    = r2_4_ff[RW-1:RL];
      r2_lo    = r2_4_ff[RL-1:0];
      lhs_in   = (QW'(chh_ff) << (2 * HL)) + (QW'(chl_ff) << (HL + 1)) + QW'(cll_ff);
      rhs_in   = (QW'(rhh_ff) << (RL + HL)) + (QW'(rhl_ff) << RL)
               + (QW'(rlh_ff) << HL) + QW'(rll_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ex_ff    <= DW'(t_x) - DW'(s_x);
         ey_ff    <= DW'(t_y) - DW'(s_y);
         cx_ff    <= DW'(p_x) - DW'(s_x);
         cy_ff    <= DW'(p_y) - DW'(s_y);
         rad_ff   <= radius;

         kx_ff    <= PW'(cx_ff) * PW'(ex_ff);
         ky_ff    <= PW'(cy_ff) * PW'(ey_ff);
         lx_ff    <= PW'(ex_ff) * PW'(ex_ff);
         ly_ff    <= PW'(ey_ff) * PW'(ey_ff);
         xa_ff    <= PW'(cx_ff) * PW'(ey_ff);
         xb_ff    <= PW'(cy_ff) * PW'(ex_ff);
         r2_2_ff  <= RW'(rad_ff) * RW'(rad_ff);

         k_ff     <= k_in;
         len_ff   <= len_in;
         cross_ff <= cross_in;
         r2_3_ff  <= r2_2_ff;

         // The centre must project strictly between the two end points.
         rng_4_ff <= (k_ff > 0) && (k_ff < len_ff);
         cr_ff    <= cr_in;
         len_u_ff <= len_ff;
         r2_4_ff  <= r2_3_ff;

         rng_5_ff <= rng_4_ff;
         chh_ff   <= (2*HH)'(cr_hi) * (2*HH)'(cr_hi);
         chl_ff   <= (HH+HL)'(cr_hi) * (HH+HL)'(cr_lo);
         cll_ff   <= (2*HL)'(cr_lo) * (2*HL)'(cr_lo);
         rll_ff   <= (RL+HL)'(r2_lo) * (RL+HL)'(len_lo);
         rlh_ff   <= (RL+HH)'(r2_lo) * (RL+HH)'(len_hi);
         rhl_ff   <= (RH+HL)'(r2_hi) * (RH+HL)'(len_lo);
         rhh_ff   <= (RH+HH)'(r2_hi) * (RH+HH)'(len_hi);

         rng_6_ff <= rng_5_ff;
         lhs_ff   <= lhs_in;
         rhs_ff   <= rhs_in;

         hit_ff   <= rng_6_ff && (lhs_ff <= rhs_ff);
      end
   end

   assign hit = hit_ff;

endmodule

### design/triangle_circle_overlap_test.sv
// ----------------------------------------------------------------------------
// Triangle / circle overlap test
// Pipelined exact-integer test of a triangle against a circle.
// ----------------------------------------------------------------------------
// Usage: one query is a transfer on the req_ stream carrying the three
// triangle vertices, the circle centre and the radius. Each query gives
// exactly one transfer on the rsp_ stream with the overlap flag and the kind
// of hit: a vertex inside the circle wins over the centre inside the
// triangle, which wins over an edge within the radius.
// A request transfer passes through seven arithmetic stages and then the
// result register before rsp_tvalid. A new query is taken every cycle
// unless a waiting result is held; the rate is set by the pipeline, whose
// longest steps are the split multiplications of the squared edge distance.
// Queries are independent, so no state survives between them.
// Reset clears every stage valid bit and the result valid bit; no result is
// presented until a new query arrives.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline freezes and req_tready drops; nothing is lost or repeated, and
// the pipeline resumes the cycle the result is taken.
// ----------------------------------------------------------------------------
module triangle_circle_overlap_test
   import tco_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0 up: a_x, a_y, b_x, b_y, c_x, c_y, center_x, center_y
   // (COORD_BITS each), radius (COORD_BITS-1), zero padding to whole bytes.
   input  logic [((9*COORD_BITS-1+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // Fields from bit 0 up: overlap (1), hit_kind (2), zero padding.
   output logic [RSP_BITS-1:0] rsp_tdata
);

   localparam int N   = COORD_BITS;
   localparam int DW  = N + 1;
   localparam int PW  = 2 * DW;
   localparam int SW  = PW + 1;
   localparam int RBW = N - 1;
   localparam int RW  = 2 * RBW;

   // Request fields.
   logic signed [N-1:0] a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y;
   logic [RBW-1:0]      radius;

   assign a_x    = req_tdata[0*N +: N];
   assign a_y    = req_tdata[1*N +: N];
   assign b_x    = req_tdata[2*N +: N];
   assign b_y    = req_tdata[3*N +: N];
   assign c_x    = req_tdata[4*N +: N];
   assign c_y    = req_tdata[5*N +: N];
   assign p_x    = req_tdata[6*N +: N];
   assign p_y    = req_tdata[7*N +: N];
   assign radius = req_tdata[8*N +: RBW];

   // The whole pipeline moves together whenever the result slot is free or
   // being emptied in this cycle.
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // Valid bits for the seven stages and the result register.
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic                  rsp_vld_ff;

   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff     <= vld_in;
         rsp_vld_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   // Stage 1: vertex offsets from the centre, and the barycentric vectors
   // v0 = C - A, v1 = B - A, v2 = P - A.
   logic signed [DW-1:0] dax_ff, day_ff, dbx_ff, dby_ff, dcx_ff, dcy_ff;
   logic signed [DW-1:0] v0x_ff, v0y_ff, v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic [RBW-1:0]       rad_ff;
   // Stage 2: squares and cross-product terms.
   logic signed [PW-1:0] sax_ff, say_ff, sbx_ff, sby_ff, scx_ff, scy_ff;
   logic signed [PW-1:0] d0_ff, d1_ff, p0_ff, p1_ff, q0_ff, q1_ff;
   logic [RW-1:0]        r2_ff;
   // Stage 3: vertex decision and the three barycentric determinants.
   logic                 vtx_3_ff;
   logic signed [SW-1:0] d_ff, p_ff, q_ff;
   // Stages 4 to 7: early decisions waiting for the edge units.
   tco_flags_type        flags_4_ff, flags_5_ff, flags_6_ff, flags_7_ff;
   // Result register.
   hit_kind_type         kind_ff;

   logic [SW-1:0]        dist_a, dist_b, dist_c;
   logic                 vtx_in;
   logic signed [SW:0]   pq_sum, d_ext;
   logic                 in_tri;
   logic [2:0]           edge_hit;
   hit_kind_type         kind_in;

   always_comb begin
      dist_a = SW'(sax_ff) + SW'(say_ff);
      dist_b = SW'(sbx_ff) + SW'(sby_ff);
      dist_c = SW'(scx_ff) + SW'(scy_ff);
      vtx_in = (dist_a <= SW'(r2_ff)) || (dist_b <= SW'(r2_ff)) || (dist_c <= SW'(r2_ff));

      // Centre inside the triangle, with the division folded into the sign
      // of the determinant. A degenerate triangle never passes.
      pq_sum = (SW+1)'(p_ff) + (SW+1)'(q_ff);
      d_ext  = (SW+1)'(d_ff);
      if (d_ff > 0) begin
         in_tri = (p_ff >= 0) && (q_ff >= 0) && (pq_sum < d_ext);
      end else if (d_ff < 0) begin
         in_tri = (p_ff <= 0) && (q_ff <= 0) && (pq_sum > d_ext);
      end else begin
         in_tri = 1'b0;
      end

      if (flags_7_ff.vertex) begin
         kind_in = HIT_VERTEX;
      end else if (flags_7_ff.center) begin
         kind_in = HIT_CENTER;
      end else if (|edge_hit) begin
         kind_in = HIT_EDGE;
      end else begin
         kind_in = HIT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dax_ff <= DW'(a_x) - DW'(p_x);
         day_ff <= DW'(a_y) - DW'(p_y);
         dbx_ff <= DW'(b_x) - DW'(p_x);
         dby_ff <= DW'(b_y) - DW'(p_y);
         dcx_ff <= DW'(c_x) - DW'(p_x);
         dcy_ff <= DW'(c_y) - DW'(p_y);
         v0x_ff <= DW'(c_x) - DW'(a_x);
         v0y_ff <= DW'(c_y) - DW'(a_y);
         v1x_ff <= DW'(b_x) - DW'(a_x);
         v1y_ff <= DW'(b_y) - DW'(a_y);
         v2x_ff <= DW'(p_x) - DW'(a_x);
         v2y_ff <= DW'(p_y) - DW'(a_y);
         rad_ff <= radius;

         sax_ff <= PW'(dax_ff) * PW'(dax_ff);
         say_ff <= PW'(day_ff) * PW'(day_ff);
         sbx_ff <= PW'(dbx_ff) * PW'(dbx_ff);
         sby_ff <= PW'(dby_ff) * PW'(dby_ff);
         scx_ff <= PW'(dcx_ff) * PW'(dcx_ff);
         scy_ff <= PW'(dcy_ff) * PW'(dcy_ff);
         d0_ff  <= PW'(v0x_ff) * PW'(v1y_ff);
         d1_ff  <= PW'(v0y_ff) * PW'(v1x_ff);
         p0_ff  <= PW'(v2x_ff) * PW'(v1y_ff);
         p1_ff  <= PW'(v2y_ff) * PW'(v1x_ff);
         q0_ff  <= PW'(v0x_ff) * PW'(v2y_ff);
         q1_ff  <= PW'(v0y_ff) * PW'(v2x_ff);
         r2_ff  <= RW'(rad_ff) * RW'(rad_ff);

         vtx_3_ff <= vtx_in;
         d_ff     <= SW'(d0_ff) - SW'(d1_ff);
         p_ff     <= SW'(p0_ff) - SW'(p1_ff);
         q_ff     <= SW'(q0_ff) - SW'(q1_ff);

         flags_4_ff.vertex <= vtx_3_ff;
         flags_4_ff.center <= in_tri;
         flags_5_ff        <= flags_4_ff;
         flags_6_ff        <= flags_5_ff;
         flags_7_ff        <= flags_6_ff;

         kind_ff <= kind_in;
      end
   end

   // Edges A->B, B->C and C->A, each in its own pipeline aligned with the
   // stages above so that its decision is ready next to flags_7_ff.
   tco_edge_unit #(.COORD_BITS(COORD_BITS)) u_edge_ab (
      .clock   (clock),
      .advance (advance),
      .s_x     (a_x),
      .s_y     (a_y),
      .t_x     (b_x),
      .t_y     (b_y),
      .p_x     (p_x),
      .p_y     (p_y),
      .radius  (radius),
      .hit     (edge_hit[0])
   );

   tco_edge_unit #(.COORD_BITS(COORD_BITS)) u_edge_bc (
      .clock   (clock),
      .advance (advance),
      .s_x     (b_x),
      .s_y     (b_y),
      .t_x     (c_x),
      .t_y     (c_y),
      .p_x     (p_x),
      .p_y     (p_y),
      .radius  (radius),
      .hit     (edge_hit[1])
   );

   tco_edge_unit #(.COORD_BITS(COORD_BITS)) u_edge_ca (
      .clock   (clock),
      .advance (advance),
      .s_x     (c_x),
      .s_y     (c_y),
      .t_x     (a_x),
      .t_y     (a_y),
      .p_x     (p_x),
      .p_y     (p_y),
      .radius  (radius),
      .hit     (edge_hit[2])
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_BITS-3){1'b0}}, kind_ff, (kind_ff != HIT_NONE)};

endmodule

### bench/tb_triangle_circle_overlap_test.sv
// ----------------------------------------------------------------------------
// Triangle / circle overlap test bench
// Drives overlap queries through the request stream and checks every response
// against an exact integer predictor. The bench covers directed geometric
// corner cases, localized random shapes at several scales, random idling on
// both streams, a long response stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb_triangle_circle_overlap_test
   import tco_pkg::*;
;

   localparam int COORD_BITS = 16;
   localparam int REQ_BITS = ((9*COORD_BITS-1+7)/8)*8;
   localparam longint COORD_MAX = (longint'(1) << (COORD_BITS-1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;
   localparam int RANDOM_QUERIES = 1100;
   localparam int HOLD_CYCLES = 60;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // One overlap query as it travels in a request transfer.
   typedef struct {
      coord_type ax, ay, bx, by, cx, cy, px, py;
      logic [COORD_BITS-2:0] radius;
   } query_type;

   // Computes the hit kind of each accepted query and holds it until the
   // matching response transfer arrives.
   class hit_tracker;
      hit_kind_type pending_hits[$];
      int errors;

      // True when the centre projects strictly inside edge S->T and its
      // distance to the edge line is at most the radius.
      static function bit near_edge(longint sx, longint sy, longint tx, longint ty,
                                    longint px, longint py, longint r2);
         longint ex, ey, dx, dy, k, len, crs;
         logic [127:0] lhs, rhs;
         ex = tx - sx;
         ey = ty - sy;
         dx = px - sx;
         dy = py - sy;
         k = dx*ex + dy*ey;
         len = ex*ex + ey*ey;
         if (!(k > 0 && k < len)) return 1'b0;
         crs = dx*ey - dy*ex;
         if (crs < 0) crs = -crs;
         // The squared cross product and r^2 * |e|^2 can exceed 64 bits.
         lhs = {64'd0, crs} * {64'd0, crs};
         rhs = {64'd0, r2} * {64'd0, len};
         return lhs <= rhs;
      endfunction

      static function hit_kind_type predict_hit(query_type q);
         longint ax, ay, bx, by, cx, cy, px, py, rr, r2;
         longint v0x, v0y, v1x, v1y, v2x, v2y, d, p, s;
         bit in_tri;
         ax = longint'(q.ax);
         ay = longint'(q.ay);
         bx = longint'(q.bx);
         by = longint'(q.by);
         cx = longint'(q.cx);
         cy = longint'(q.cy);
         px = longint'(q.px);
         py = longint'(q.py);
         rr = longint'(q.radius);
         r2 = rr*rr;
         if ((ax-px)*(ax-px) + (ay-py)*(ay-py) <= r2 ||
             (bx-px)*(bx-px) + (by-py)*(by-py) <= r2 ||
             (cx-px)*(cx-px) + (cy-py)*(cy-py) <= r2)
            return HIT_VERTEX;
         // Barycentric test with the division folded into the sign of D.
         v0x = cx - ax;
         v0y = cy - ay;
         v1x = bx - ax;
         v1y = by - ay;
         v2x = px - ax;
         v2y = py - ay;
         d = v0x*v1y - v0y*v1x;
         p = v2x*v1y - v2y*v1x;
         s = v0x*v2y - v0y*v2x;
         in_tri = 1'b0;
         if (d > 0)
            in_tri = p >= 0 && s >= 0 && p + s < d;
         else if (d < 0)
            in_tri = p <= 0 && s <= 0 && p + s > d;
         if (in_tri) return HIT_CENTER;
         if (near_edge(ax, ay, bx, by, px, py, r2) ||
             near_edge(bx, by, cx, cy, px, py, r2) ||
             near_edge(cx, cy, ax, ay, px, py, r2))
            return HIT_EDGE;
         return HIT_NONE;
      endfunction

      function void note_query(query_type q);
         pending_hits.push_back(predict_hit(q));
      endfunction

      function void check_result(logic [RSP_BITS-1:0] data);
         hit_kind_type want;
         if (pending_hits.size() == 0) begin
            $display("%0t: response overlap=%0b hit_kind=%0d with no query outstanding",
                     $time, data[0], data[2:1]);
            errors++;
            return;
         end
         want = pending_hits.pop_front();
         if (data[0] !== (want != HIT_NONE)) begin
            $display("%0t: overlap mismatch, expected %0b, actual %0b",
                     $time, want != HIT_NONE, data[0]);
            errors++;
         end
         if (data[2:1] !== want) begin
            $display("%0t: hit_kind mismatch, expected %0d, actual %0d",
                     $time, want, data[2:1]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // Fields from bit 0 up: a_x, a_y, b_x, b_y, c_x, c_y, center_x, center_y,
   // radius, zero padding.
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // Fields from bit 0 up: overlap, hit_kind, zero padding.
   logic [RSP_BITS-1:0] rsp_tdata;

   // When set, neither stream inserts idle cycles, giving back-to-back runs.
   bit no_idle = 1'b0;

   hit_tracker hits = new();

   triangle_circle_overlap_test #(
      .COORD_BITS(COORD_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic query_type shape(int ax, int ay, int bx, int by, int cx, int cy,
                                       int px, int py, int r);
      query_type q;
      q.ax = coord_type'(ax);
      q.ay = coord_type'(ay);
      q.bx = coord_type'(bx);
      q.by = coord_type'(by);
      q.cx = coord_type'(cx);
      q.cy = coord_type'(cy);
      q.px = coord_type'(px);
      q.py = coord_type'(py);
      q.radius = (COORD_BITS-1)'(r);
      return q;
   endfunction

   // A point within span of the base, saturated to the coordinate range.
   function automatic coord_type jitter(longint base, int span);
      longint v;
      v = base + longint'($urandom_range(0, 2*span)) - longint'(span);
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      return coord_type'(v);
   endfunction

   // Most queries cluster the triangle and the circle around one point so
   // that every kind of hit shows up; the rest are fully random or built
   // from the extreme coordinate values.
   function automatic query_type random_query();
      query_type q;
      coord_type corner[4];
      longint base_x, base_y;
      int span;
      int pick;
      corner = '{coord_type'(COORD_MIN), coord_type'(COORD_MAX), coord_type'(0),
                 coord_type'(-1)};
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         q.ax = coord_type'($urandom);
         q.ay = coord_type'($urandom);
         q.bx = coord_type'($urandom);
         q.by = coord_type'($urandom);
         q.cx = coord_type'($urandom);
         q.cy = coord_type'($urandom);
         q.px = coord_type'($urandom);
         q.py = coord_type'($urandom);
         q.radius = (COORD_BITS-1)'($urandom);
      end else if (pick == 9) begin
         q.ax = corner[$urandom_range(0, 3)];
         q.ay = corner[$urandom_range(0, 3)];
         q.bx = corner[$urandom_range(0, 3)];
         q.by = corner[$urandom_range(0, 3)];
         q.cx = corner[$urandom_range(0, 3)];
         q.cy = corner[$urandom_range(0, 3)];
         q.px = corner[$urandom_range(0, 3)];
         q.py = corner[$urandom_range(0, 3)];
         case ($urandom_range(0, 2))
            0: q.radius = '0;
            1: q.radius = (COORD_BITS-1)'(1);
            default: q.radius = (COORD_BITS-1)'(COORD_MAX);
         endcase
      end else begin
         case ($urandom_range(0, 3))
            0: span = 8;
            1: span = 200;
            2: span = 5000;
            default: span = int'(COORD_MAX);
         endcase
         base_x = longint'(coord_type'($urandom));
         base_y = longint'(coord_type'($urandom));
         q.ax = jitter(base_x, span);
         q.ay = jitter(base_y, span);
         q.bx = jitter(base_x, span);
         q.by = jitter(base_y, span);
         q.cx = jitter(base_x, span);
         q.cy = jitter(base_y, span);
         q.px = jitter(base_x, span);
         q.py = jitter(base_y, span);
         q.radius = (COORD_BITS-1)'($urandom_range(0, span/2));
      end
      return q;
   endfunction

   // Presents one query after a random gap and returns once the request
   // transfer has happened. The valid stays high when the next query follows
   // with no gap, so it is never lowered and raised in the same step.
   task automatic offer_query(input query_type q);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_BITS'({q.radius, q.py, q.px, q.cy, q.cx, q.by, q.bx, q.ay, q.ax});
      do @(posedge clock); while (!req_tready);
      hits.note_query(q);
   endtask

   // Response side. It draws a stall before every result and, twice during
   // the random part, holds off for a long stretch so that the pipeline fills
   // up and the request stream backs up.
   initial begin : result_side
      int stall;
      int taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (taken == 250 || taken == 800) stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         hits.check_result(rsp_tdata);
         taken++;
      end
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extremes of the coordinate range, with zero and full radius.
      offer_query(shape(0, 0, 0, 0, 0, 0, 0, 0, 0));
      offer_query(shape(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0));
      offer_query(shape(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      offer_query(shape(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767, 0));
      offer_query(shape(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767, 32767));
      offer_query(shape(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768, 32767));
      // A vertex inside the circle, one case per vertex.
      offer_query(shape(10, 10, 500, 10, 10, 500, 12, 13, 4));
      offer_query(shape(10, 10, 500, 10, 10, 500, 498, 12, 3));
      offer_query(shape(10, 10, 500, 10, 10, 500, 10, 497, 3));
      // Centre inside the triangle for both windings, and with zero radius.
      offer_query(shape(0, 0, 100, 0, 0, 100, 20, 30, 2));
      offer_query(shape(0, 0, 0, 100, 100, 0, 20, 30, 2));
      offer_query(shape(0, 0, 100, 0, 0, 100, 20, 30, 0));
      // Zero radius with the centre exactly on the hypotenuse.
      offer_query(shape(0, 0, 100, 0, 0, 100, 50, 50, 0));
      // An edge within the radius, one case per edge, then just out of reach.
      offer_query(shape(0, 0, 100, 0, 0, 100, 50, -5, 5));
      offer_query(shape(0, 0, 100, 0, 0, 100, 55, 55, 8));
      offer_query(shape(0, 0, 100, 0, 0, 100, -5, 50, 5));
      offer_query(shape(0, 0, 100, 0, 0, 100, 50, -6, 5));
      // Centre beside an edge but beyond its end point.
      offer_query(shape(0, 0, 100, 0, 0, 100, 110, -3, 5));
      // Degenerate (collinear) triangle: only the vertex and edge tests can hit.
      offer_query(shape(0, 0, 100, 0, 200, 0, 50, 3, 5));
      offer_query(shape(0, 0, 100, 0, 200, 0, 50, 300, 5));
      // A zero-length edge never hits; all three vertices on one point.
      offer_query(shape(0, 0, 0, 0, 100, 0, 0, 50, 10));
      offer_query(shape(7, 7, 7, 7, 7, 7, 100, 100, 3));
      // Alternating bit patterns in every field.
      offer_query(shape(21845, -21846, 21845, -21846, 21845, -21846, 21845, -21846, 21845));
      offer_query(shape(-21846, 21845, -21846, 21845, -21846, 21845, -21846, 21845, 10922));

      for (int i = 0; i < RANDOM_QUERIES; i++) begin
         // Every fourth block of a hundred runs with no idling on either side.
         no_idle = ((i / 100) % 4) == 3;
         if (i == 550) begin
            // Let the pipeline drain completely before going on.
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (hits.pending_hits.size() != 0) @(posedge clock);
         end
         offer_query(random_query());
      end
      req_tvalid <= 1'b0;
      no_idle = 1'b0;

      while (hits.pending_hits.size() != 0) @(posedge clock);
      // A few more cycles catch any response that should not exist.
      repeat (PIPE_DEPTH + 8) @(posedge clock);
      if (hits.errors == 0)
         $display("triangle_circle_overlap_test test passed");
      else
         $display("triangle_circle_overlap_test test failed");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("triangle_circle_overlap_test test failed");
      $finish;
   end

endmodule
